// ===== hw/rtl/fdtsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fdtsp_pkg
// Shared types and constants for the devicetree structure block parser.
// ----------------------------------------------------------------------------
package fdtsp_pkg;

    // offsets are kept modulo this span
    localparam int OFF_W    = 20;
    localparam int OFF_SPAN = 1 << OFF_W;
    localparam int SKIP_W   = 18;

    // default structure block size in bytes
    localparam int BLOCK_BYTES_DEFAULT = 1048576;

    // structure block tokens
    localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
    localparam logic [31:0] TOK_END_NODE   = 32'd2;
    localparam logic [31:0] TOK_PROP       = 32'd3;
    localparam logic [31:0] TOK_NOP        = 32'd4;
    localparam logic [31:0] TOK_END        = 32'd9;

    // event kinds
    localparam logic [1:0] KIND_PROP     = 2'd0;
    localparam logic [1:0] KIND_END      = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN  = 2'd2;
    localparam logic [1:0] KIND_TOOLARGE = 2'd3;

    // one event produced by the decoder
    typedef struct packed {
        logic             hit;
        logic [1:0]       kind;
        logic [OFF_W-1:0] node;
        logic [OFF_W-1:0] name;
        logic [OFF_W-1:0] len;
        logic [OFF_W-1:0] data;
    } fdtsp_result_t;

    // decoder status seen by the top level
    typedef struct packed {
        logic             stopped;
        logic [OFF_W-1:0] byte_offset;
    } fdtsp_status_t;

endpackage

// ===== hw/rtl/fdtsp_decoder.sv =====
// ----------------------------------------------------------------------------
// fdtsp_decoder
// Parser state and the per-word next-state and event logic.
// ----------------------------------------------------------------------------
module fdtsp_decoder
    import fdtsp_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [31:0]   word,
    input  logic          first,
    output fdtsp_result_t res,
    output fdtsp_status_t status
);

    localparam int BOUND_I = (BLOCK_BYTES > OFF_SPAN) ? OFF_SPAN : BLOCK_BYTES;
    localparam logic [32:0] BOUND = 33'(BOUND_I);

    typedef enum logic [4:0] {
        PH_TOKEN   = 5'b00001,
        PH_NAME    = 5'b00010,
        PH_LEN     = 5'b00100,
        PH_NAMEOFF = 5'b01000,
        PH_SKIP    = 5'b10000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [OFF_W-1:0]  offset_reg, offset_next;
    logic [OFF_W-1:0]  node_reg, node_next;
    logic [OFF_W-1:0]  pend_reg, pend_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic              stopped_reg, stopped_next;

    // state as seen by this word, after a restart marker
    phase_t            phase_cur;
    logic [OFF_W-1:0]  here;
    logic [OFF_W-1:0]  node_cur;
    logic [OFF_W-1:0]  pend_cur;
    logic [SKIP_W-1:0] skip_cur;
    logic              active;

    logic [OFF_W-1:0]  here4;
    logic [OFF_W-1:0]  here8;
    logic [32:0]       len_end;
    logic              zero_byte;
    logic [OFF_W:0]    pend_round;
    logic [SKIP_W-1:0] skip_load;

    assign phase_cur = first ? PH_TOKEN : phase_reg;
    assign here      = first ? '0 : offset_reg;
    assign node_cur  = first ? '0 : node_reg;
    assign pend_cur  = first ? '0 : pend_reg;
    assign skip_cur  = first ? '0 : skip_reg;
    assign active    = first || !stopped_reg;

    assign here4      = here + OFF_W'(4);
    assign here8      = here + OFF_W'(8);
    assign len_end    = {1'b0, word} + {13'd0, here8};
    assign zero_byte  = (word[31:24] == 8'd0) || (word[23:16] == 8'd0) ||
                        (word[15:8] == 8'd0) || (word[7:0] == 8'd0);
    assign pend_round = {1'b0, pend_cur} + (OFF_W+1)'(3);
    assign skip_load  = pend_round[SKIP_W+1:2];

    // next state and event for one word
    always_comb
    begin
        phase_next   = phase_cur;
        offset_next  = here4;
        node_next    = node_cur;
        pend_next    = pend_cur;
        skip_next    = skip_cur;
        stopped_next = 1'b0;
        res.hit      = 1'b0;
        res.kind     = KIND_PROP;
        res.node     = node_cur;
        res.name     = '0;
        res.len      = '0;
        res.data     = here;
        case (phase_cur)
            PH_NAME:
            begin
                if (zero_byte)
                    phase_next = PH_TOKEN;
            end
            PH_LEN:
            begin
                if (len_end > BOUND)
                begin
                    res.hit      = 1'b1;
                    res.kind     = KIND_TOOLARGE;
                    res.len      = word[OFF_W-1:0];
                    res.data     = here8;
                    stopped_next = 1'b1;
                    phase_next   = PH_TOKEN;
                end
                else
                begin
                    pend_next  = word[OFF_W-1:0];
                    phase_next = PH_NAMEOFF;
                end
            end
            PH_NAMEOFF:
            begin
                res.hit    = 1'b1;
                res.kind   = KIND_PROP;
                res.name   = word[OFF_W-1:0];
                res.len    = pend_cur;
                res.data   = here4;
                skip_next  = skip_load;
                phase_next = (skip_load != '0) ? PH_SKIP : PH_TOKEN;
            end
            PH_SKIP:
            begin
                if (skip_cur != '0)
                    skip_next = skip_cur - SKIP_W'(1);
                if (skip_cur <= SKIP_W'(1))
                    phase_next = PH_TOKEN;
            end
            default:
            begin
                // token word
                phase_next = PH_TOKEN;
                if (word == TOK_BEGIN_NODE)
                begin
                    node_next  = here4;
                    phase_next = PH_NAME;
                end
                else if (word == TOK_PROP)
                begin
                    phase_next = PH_LEN;
                end
                else if (word == TOK_END_NODE || word == TOK_NOP)
                begin
                    phase_next = PH_TOKEN;
                end
                else
                begin
                    res.hit      = 1'b1;
                    res.kind     = (word == TOK_END) ? KIND_END : KIND_UNKNOWN;
                    stopped_next = 1'b1;
                end
            end
        endcase
        // ignored word while stopped
        if (!active)
            res.hit = 1'b0;
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TOKEN;
            offset_reg  <= '0;
            node_reg    <= '0;
            pend_reg    <= '0;
            skip_reg    <= '0;
            stopped_reg <= 1'b0;
        end
        else if (step && active)
        begin
            phase_reg   <= phase_next;
            offset_reg  <= offset_next;
            node_reg    <= node_next;
            pend_reg    <= pend_next;
            skip_reg    <= skip_next;
            stopped_reg <= stopped_next;
        end
    end

    assign status.stopped     = stopped_reg;
    assign status.byte_offset = offset_reg;

endmodule

// ===== hw/rtl/fdtsp_out_stage.sv =====
// ----------------------------------------------------------------------------
// fdtsp_out_stage
// Event output register with valid and ready handshake.
// ----------------------------------------------------------------------------
module fdtsp_out_stage
    import fdtsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  fdtsp_result_t    res,
    output logic             free,
    output logic             event_valid,
    input  logic             event_ready,
    output logic [1:0]       event_kind,
    output logic [OFF_W-1:0] node_name_offset,
    output logic [OFF_W-1:0] prop_name_offset,
    output logic [OFF_W-1:0] prop_length,
    output logic [OFF_W-1:0] prop_data_offset
);

    logic             valid_reg;
    logic [1:0]       kind_reg;
    logic [OFF_W-1:0] node_reg;
    logic [OFF_W-1:0] name_reg;
    logic [OFF_W-1:0] len_reg;
    logic [OFF_W-1:0] data_reg;

    assign free = !valid_reg || event_ready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= res.hit;
        else if (event_ready)
            valid_reg <= 1'b0;
    end

    // event payload
    always_ff @(posedge clk)
    begin
        if (load && res.hit)
        begin
            kind_reg <= res.kind;
            node_reg <= res.node;
            name_reg <= res.name;
            len_reg  <= res.len;
            data_reg <= res.data;
        end
    end

    assign event_valid      = valid_reg;
    assign event_kind       = kind_reg;
    assign node_name_offset = node_reg;
    assign prop_name_offset = name_reg;
    assign prop_length      = len_reg;
    assign prop_data_offset = data_reg;

endmodule

// ===== hw/rtl/fdt_struct_block_parser.sv =====
// ----------------------------------------------------------------------------
// fdt_struct_block_parser
// Streaming parser for the structure block of a flattened devicetree.
// ----------------------------------------------------------------------------
// Takes one 32-bit big-endian structure word per cycle and emits at most one
// event per word: a property event after each PROP name-offset word, or a
// final event on END, an unknown token or an oversized length, after which
// words are dropped until the next word flagged first_word. Sustained rate is
// one word per clock while event_ready stays high; a word that is taken passes
// from the input register into the event register, where its event is valid.
// A held event stalls the input only while event_ready is low.
// ----------------------------------------------------------------------------
module fdt_struct_block_parser
    import fdtsp_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             struct_valid,
    output logic             struct_ready,
    input  logic [31:0]      struct_word,
    input  logic             first_word,
    output logic             event_valid,
    input  logic             event_ready,
    output logic [1:0]       event_kind,
    output logic [OFF_W-1:0] node_name_offset,
    output logic [OFF_W-1:0] prop_name_offset,
    output logic [OFF_W-1:0] prop_length,
    output logic [OFF_W-1:0] prop_data_offset
);

    logic          in_valid_reg;
    logic [31:0]   in_word_reg;
    logic          in_first_reg;
    logic          out_free;
    logic          advance;
    fdtsp_result_t res;
    fdtsp_status_t status;

    assign advance      = in_valid_reg && out_free;
    assign struct_ready = !in_valid_reg || advance;

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (struct_ready)
            in_valid_reg <= struct_valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (struct_valid && struct_ready)
        begin
            in_word_reg  <= struct_word;
            in_first_reg <= first_word;
        end
    end

    // word decoder and parser state
    fdtsp_decoder #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_decoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .word   (in_word_reg),
        .first  (in_first_reg),
        .res    (res),
        .status (status)
    );

    // event register
    fdtsp_out_stage u_out_stage (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (advance),
        .res              (res),
        .free             (out_free),
        .event_valid      (event_valid),
        .event_ready      (event_ready),
        .event_kind       (event_kind),
        .node_name_offset (node_name_offset),
        .prop_name_offset (prop_name_offset),
        .prop_length      (prop_length),
        .prop_data_offset (prop_data_offset)
    );

    // restart marker puts the next word at offset four
    a_restart_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_first_reg) |=> (status.byte_offset == OFF_W'(4)))
        else $error("offset not restarted by first word");

    // stopped parser gives no event without a restart
    a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_first_reg && status.stopped) |-> !res.hit)
        else $error("event produced while stopped");

    // final events stop the parser
    a_final_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.hit && res.kind != KIND_PROP) |=> status.stopped)
        else $error("parser not stopped after final event");

    // an empty input register always takes a transaction
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> struct_ready)
        else $error("input stalled while empty");

endmodule
